// File: hdl/bgss_pkg.sv
// shared types, constants and register codes for the balance gain schedule supervisor
`timescale 1ns / 1ps

package bgss_pkg;

  // drive output history
  localparam int WINDOW_LEN = 10;
  localparam int WIN_IDX_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

  // base gains, Q8.16 and Q8.8
  localparam logic [23:0]        KP_BASE      = 24'd589824;
  localparam logic [23:0]        KD_BASE      = 24'd819200;
  localparam logic [23:0]        KI_RIDERLESS = 24'd9830;
  localparam logic signed [15:0] SP_RIDERLESS = 16'sd1843;
  localparam logic signed [15:0] SP_RIDER     = 16'sd0;
  localparam logic [23:0]        KP_BOUNDED   = 24'd655360;
  localparam logic [23:0]        KI_BOUNDED   = 24'd7864;
  localparam logic [23:0]        GAIN_MAX     = 24'hFFFFFF;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_BOUNDED_ANGLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT_STEP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OVERRIDE_HOLD_MS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN_MS      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_THRESHOLD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KP_BOOST         = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_FACTOR     = 3'd6;

  typedef struct packed {
    logic               rider_mode;
    logic signed [15:0] tilt_angle;
    logic signed [15:0] drive_output;
    logic signed [31:0] integral_in;
    logic [31:0]        now_ms;
  } in_t;

  typedef struct packed {
    logic signed [15:0] setpoint_out;
    logic [23:0]        kp_out;
    logic [23:0]        ki_out;
    logic [23:0]        kd_out;
    logic signed [31:0] integral_out;
    logic               override_active;
  } out_t;

  typedef struct packed {
    logic [14:0] bounded_angle;
    logic [14:0] setpoint_step;
    logic [15:0] override_hold_ms;
    logic [15:0] cooldown_ms;
    logic [14:0] output_threshold;
    logic [23:0] kp_boost;
    logic [15:0] decay_factor;
  } cfg_t;

  // supervisor state kept across beats
  typedef struct packed {
    logic               last_rider_mode;
    logic               reload_pending;
    logic signed [15:0] setpoint;
    logic [23:0]        kp;
    logic [23:0]        ki;
    logic [23:0]        kd;
    logic               override_flag;
    logic [31:0]        override_stamp;
  } sup_t;

  // controller to datapath
  typedef struct packed {
    logic                 load_item;
    logic                 prep;
    logic                 ride;
    logic                 decay;
    logic                 hold;
    logic                 scan;
    logic                 boost;
    logic                 load_out;
    logic [WIN_IDX_W-1:0] scan_idx;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rider;
    logic override_flag;
    logic out_free;
  } sts_t;

endpackage

// File: hdl/bgss_if.sv
// valid/ready channel interfaces for input and result beats
`timescale 1ns / 1ps

interface bgss_in_if import bgss_pkg::*; ();
  logic valid;
  logic ready;
  in_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface bgss_out_if import bgss_pkg::*; ();
  logic valid;
  logic ready;
  out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/balance_gain_schedule_supervisor_top.sv
// Gain scheduler for a balancing PID loop: one input beat per control step in, one result beat out.
// Channels: item_i (sink) carries rider mode, tilt, drive output, integral and a ms timestamp;
// result_o (source) carries setpoint, Kp/Ki/Kd, the updated integral and the override flag.
// Both use valid/ready; a beat moves on a rising edge with valid and ready high.
// Configuration goes through cfg_we_i/cfg_idx_i/cfg_data_i, one register per write,
// and the user must write it only while no beat is in flight; the block does not enforce this.
// A rider beat passes through reload, band and 32x16 decay multiply, decay apply and result
// load; a riderless beat in override through reload, hold expiry check and result load; a
// riderless beat without override through reload, the walk over the drive output window at
// one entry per cycle, boost and result load. The result load waits for a free result register.
// One beat at a time: the next beat is taken in the cycle after the previous result is loaded.
// The result register frees the controller: a new beat is accepted while a result
// waits; if the receiver stalls, a second finished result waits in the controller
// and input ready stays low until the first is taken.
// Reset: config registers return to their defaults, gains and setpoint clear,
// the window clears and a gain reload is forced on the first beat.
`timescale 1ns / 1ps

module balance_gain_schedule_supervisor_top import bgss_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  bgss_in_if.sink               item_i,
  bgss_out_if.source            result_o
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;
  logic out_valid;
  out_t out_payload;

  bgss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bgss_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_payload_i  (item_i.payload),
    .out_ready_i   (result_o.ready),
    .out_valid_o   (out_valid),
    .out_payload_o (out_payload),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

  // channel hookup
  assign item_i.ready     = in_ready;
  assign result_o.valid   = out_valid;
  assign result_o.payload = out_payload;

endmodule

// File: hdl/bgss_datapath.sv
// datapath: config registers, supervisor state, output window, decay multiply, result register
`timescale 1ns / 1ps

module bgss_datapath import bgss_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  in_t                   in_payload_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output out_t                  out_payload_o,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o
);

  cfg_t cfg_q, cfg_d;
  sup_t sup_q, sup_d;
  logic signed [15:0] win_q [WINDOW_LEN];
  logic signed [15:0] win_d [WINDOW_LEN];
  logic all_hi_q, all_hi_d, all_lo_q, all_lo_d;
  logic band_q, band_d, neg_q, neg_d;
  logic out_valid_q, out_valid_d;

  in_t                in_q, in_d;
  logic signed [31:0] integ_q, integ_d;
  logic [47:0]        prod_q, prod_d;
  out_t               out_q, out_d;

  // shared intermediates
  logic               reload;
  logic [16:0]        tilt_mag;
  logic [31:0]        integ_mag;
  logic [31:0]        decayed;
  logic [31:0]        dt;
  logic signed [16:0] win_ext;
  logic signed [16:0] th_pos;
  logic signed [16:0] th_neg;
  logic signed [16:0] sp_sum;
  logic [24:0]        kp_sum;
  logic               taken;

  assign reload    = (in_q.rider_mode != sup_q.last_rider_mode) || sup_q.reload_pending;
  assign tilt_mag  = in_q.tilt_angle[15] ? (17'd0 - {in_q.tilt_angle[15], in_q.tilt_angle})
                                         : {1'b0, in_q.tilt_angle};
  assign integ_mag = integ_q[31] ? (~integ_q + 32'd1) : integ_q;
  assign decayed   = prod_q[47:16];
  assign dt        = in_q.now_ms - sup_q.override_stamp;
  assign win_ext   = {win_q[cmd_i.scan_idx][15], win_q[cmd_i.scan_idx]};
  assign th_pos    = $signed({2'b00, cfg_q.output_threshold});
  assign th_neg    = -th_pos;
  assign sp_sum    = all_hi_q ? ({sup_q.setpoint[15], sup_q.setpoint} +
                                 $signed({2'b00, cfg_q.setpoint_step}))
                              : ({sup_q.setpoint[15], sup_q.setpoint} -
                                 $signed({2'b00, cfg_q.setpoint_step}));
  assign kp_sum    = {1'b0, sup_q.kp} + {1'b0, cfg_q.kp_boost};
  assign taken     = out_valid_q && out_ready_i;

  // next-state logic
  always_comb begin
    cfg_d       = cfg_q;
    sup_d       = sup_q;
    win_d       = win_q;
    all_hi_d    = all_hi_q;
    all_lo_d    = all_lo_q;
    band_d      = band_q;
    neg_d       = neg_q;
    in_d        = in_q;
    integ_d     = integ_q;
    prod_d      = prod_q;
    out_d       = out_q;
    out_valid_d = taken ? 1'b0 : out_valid_q;

    // configuration writes
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BOUNDED_ANGLE:    cfg_d.bounded_angle    = cfg_data_i[14:0];
        REG_SETPOINT_STEP:    cfg_d.setpoint_step    = cfg_data_i[14:0];
        REG_OVERRIDE_HOLD_MS: cfg_d.override_hold_ms = cfg_data_i[15:0];
        REG_COOLDOWN_MS:      cfg_d.cooldown_ms      = cfg_data_i[15:0];
        REG_OUTPUT_THRESHOLD: cfg_d.output_threshold = cfg_data_i[14:0];
        REG_KP_BOOST:         cfg_d.kp_boost         = cfg_data_i[23:0];
        REG_DECAY_FACTOR:     cfg_d.decay_factor     = cfg_data_i[15:0];
        default: ;
      endcase
    end

    if (cmd_i.load_item) begin
      in_d = in_payload_i;
    end

    // mode change reload and window update
    if (cmd_i.prep) begin
      integ_d  = reload ? 32'sd0 : in_q.integral_in;
      all_hi_d = 1'b1;
      all_lo_d = 1'b1;
      if (reload) begin
        sup_d.last_rider_mode = in_q.rider_mode;
        sup_d.setpoint        = in_q.rider_mode ? SP_RIDER : SP_RIDERLESS;
        sup_d.kp              = KP_BASE;
        sup_d.kd              = KD_BASE;
        sup_d.ki              = in_q.rider_mode ? 24'd0 : KI_RIDERLESS;
        sup_d.reload_pending  = 1'b0;
      end
      if (!in_q.rider_mode && !sup_q.override_flag) begin
        for (int i = 0; i < WINDOW_LEN - 1; i++) begin
          win_d[i] = win_q[i+1];
        end
        win_d[WINDOW_LEN-1] = in_q.drive_output;
      end
    end

    // rider gains by tilt band, start of integral decay
    if (cmd_i.ride) begin
      band_d = tilt_mag < {2'b00, cfg_q.bounded_angle};
      neg_d  = integ_q[31];
      prod_d = 48'(integ_mag) * 48'(cfg_q.decay_factor);
      sup_d.kd = KD_BASE;
      if (tilt_mag < {2'b00, cfg_q.bounded_angle}) begin
        sup_d.kp = KP_BOUNDED;
        sup_d.ki = KI_BOUNDED;
      end else begin
        sup_d.kp = KP_BASE;
        sup_d.ki = 24'd0;
      end
    end

    // apply decayed integral outside the band
    if (cmd_i.decay && !band_q) begin
      integ_d = neg_q ? $signed(32'd0 - decayed) : $signed(decayed);
    end

    // override hold expiry
    if (cmd_i.hold && (dt > {16'd0, cfg_q.override_hold_ms})) begin
      sup_d.override_flag  = 1'b0;
      sup_d.reload_pending = 1'b1;
      sup_d.override_stamp = in_q.now_ms;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_d[i] = 16'sd0;
      end
    end

    // one window entry per cycle against the threshold
    if (cmd_i.scan) begin
      all_hi_d = all_hi_q && (win_ext > th_pos);
      all_lo_d = all_lo_q && (win_ext < th_neg);
    end

    // override start
    if (cmd_i.boost && (dt > {16'd0, cfg_q.cooldown_ms}) && (all_hi_q || all_lo_q)) begin
      if (sp_sum > 17'sd32767) begin
        sup_d.setpoint = 16'sh7FFF;
      end else if (sp_sum < -17'sd32768) begin
        sup_d.setpoint = 16'sh8000;
      end else begin
        sup_d.setpoint = sp_sum[15:0];
      end
      sup_d.kp             = kp_sum[24] ? GAIN_MAX : kp_sum[23:0];
      sup_d.override_flag  = 1'b1;
      sup_d.override_stamp = in_q.now_ms;
    end

    // result register
    if (cmd_i.load_out) begin
      out_d.setpoint_out    = sup_q.setpoint;
      out_d.kp_out          = sup_q.kp;
      out_d.ki_out          = sup_q.ki;
      out_d.kd_out          = sup_q.kd;
      out_d.integral_out    = integ_q;
      out_d.override_active = sup_q.override_flag;
      out_valid_d           = 1'b1;
    end
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bounded_angle    <= 15'd768;
      cfg_q.setpoint_step    <= 15'd512;
      cfg_q.override_hold_ms <= 16'd1000;
      cfg_q.cooldown_ms      <= 16'd1000;
      cfg_q.output_threshold <= 15'd10;
      cfg_q.kp_boost         <= 24'd196608;
      cfg_q.decay_factor     <= 16'd64225;
      sup_q.last_rider_mode  <= 1'b0;
      sup_q.reload_pending   <= 1'b1;
      sup_q.setpoint         <= 16'sd0;
      sup_q.kp               <= 24'd0;
      sup_q.ki               <= 24'd0;
      sup_q.kd               <= 24'd0;
      sup_q.override_flag    <= 1'b0;
      sup_q.override_stamp   <= 32'd0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_q[i] <= 16'sd0;
      end
      all_hi_q    <= 1'b0;
      all_lo_q    <= 1'b0;
      band_q      <= 1'b0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      sup_q       <= sup_d;
      win_q       <= win_d;
      all_hi_q    <= all_hi_d;
      all_lo_q    <= all_lo_d;
      band_q      <= band_d;
      neg_q       <= neg_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    in_q    <= in_d;
    integ_q <= integ_d;
    prod_q  <= prod_d;
    out_q   <= out_d;
  end

  assign out_valid_o       = out_valid_q;
  assign out_payload_o     = out_q;
  assign sts_o.rider         = in_q.rider_mode;
  assign sts_o.override_flag = sup_q.override_flag;
  assign sts_o.out_free      = !out_valid_q || out_ready_i;

endmodule

// File: hdl/bgss_ctrl.sv
// controller: sequences reload, rider, hold, window scan and boost steps for one beat
`timescale 1ns / 1ps

module bgss_ctrl import bgss_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_RIDE  = 3'd2;
  localparam logic [2:0] S_DECAY = 3'd3;
  localparam logic [2:0] S_HOLD  = 3'd4;
  localparam logic [2:0] S_SCAN  = 3'd5;
  localparam logic [2:0] S_BOOST = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  localparam logic [WIN_IDX_W-1:0] SCAN_LAST = WIN_IDX_W'(WINDOW_LEN - 1);

  logic [2:0]           state_q, state_d;
  logic [WIN_IDX_W-1:0] cnt_q, cnt_d;

  // step sequencing
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    cmd_o.scan_idx = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        cnt_d      = '0;
        if (sts_i.rider) begin
          state_d = S_RIDE;
        end else if (sts_i.override_flag) begin
          state_d = S_HOLD;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_RIDE: begin
        cmd_o.ride = 1'b1;
        state_d    = S_DECAY;
      end
      S_DECAY: begin
        cmd_o.decay = 1'b1;
        state_d     = S_DONE;
      end
      S_HOLD: begin
        cmd_o.hold = 1'b1;
        state_d    = S_DONE;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (cnt_q == SCAN_LAST) begin
          state_d = S_BOOST;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_BOOST: begin
        cmd_o.boost = 1'b1;
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule
